>>> src/chained_hash_table_engine_macros.svh
// assertion macros for the chained hash table engine checker
// no dependencies
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define CHTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/chte_pkg.sv
// shared types and constants for the chained hash table engine
// no dependencies
package chte_pkg;

	localparam int NUM_BUCKETS_DEF = 64;
	localparam int CHAIN_DEPTH_DEF = 4;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 31;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET    = 2'd0,
		KIND_GET    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_RSVD   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_MISS    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_BASE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage

>>> src/chained_hash_table_engine.sv
// top level of the chained hash table engine: sequencer, shared divider, chain scan
// depends on chte_pkg and chte_ram
//
//  channel   signals                                     handshake
//  request   start, busy, kind, key, value               start & !busy
//  result    done, found, read_value, status             done strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_data              cfg_valid & cfg_ready
//
// an item passes from accept to done through 31 steps of the shared restoring
// divider for the bucket, one for the bucket base, a read and a check per chain
// slot through the registered ram read port, and one to write back. a reserved
// kind goes straight to the last step, and a hit ends the chain scan early.
// after reset a clearing pass over all NUM_BUCKETS*CHAIN_DEPTH slots holds busy high.
// results cannot be stalled; done is high for one cycle per item.
module chained_hash_table_engine #(
	parameter int NUM_BUCKETS = chte_pkg::NUM_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chte_pkg::CHAIN_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [chte_pkg::KIND_W-1:0]    kind,
	input  logic [chte_pkg::KEY_W-1:0]     key,
	input  logic [chte_pkg::VALUE_W-1:0]   value,
	output logic                           done,
	output logic                           found,
	output logic [chte_pkg::VALUE_W-1:0]   read_value,
	output logic [chte_pkg::STATUS_W-1:0]  status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [chte_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SLOTS   = NUM_BUCKETS * CHAIN_DEPTH;
	localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int CNT_W   = $clog2(chte_pkg::KEY_W);
	localparam int CFG_W   = chte_pkg::CFG_W;
	localparam int KEY_W   = chte_pkg::KEY_W;
	localparam int VALUE_W = chte_pkg::VALUE_W;
	localparam int ENTRY_W = $bits(chte_pkg::entry_t);

	chte_pkg::state_t  state_q, state_d;
	chte_pkg::kind_t   kind_q;
	chte_pkg::status_t status_q, fin_status;

	logic [ADDR_W-1:0]  clr_q;
	logic [CFG_W-1:0]   bc_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               hit_q;
	logic               free_q;

	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   keysh_q;
	logic [VALUE_W-1:0] value_q;
	logic [CFG_W-1:0]   div_q;
	logic [CFG_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  hit_addr_q;
	logic [VALUE_W-1:0] hit_value_q;
	logic [ADDR_W-1:0]  free_addr_q;
	logic               found_q;
	logic [VALUE_W-1:0] rd_q;

	logic [CFG_W-1:0]   used_bc;
	logic [CFG_W:0]     trial;
	logic [CFG_W-1:0]   rem_d;
	logic [ADDR_W-1:0]  scan_addr;
	logic               slot_last;
	logic               accept;
	logic               match;
	chte_pkg::entry_t   rd_entry;
	logic               fin_found;
	logic [VALUE_W-1:0] fin_rd;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	chte_pkg::entry_t   ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	assign accept    = start && !busy;
	assign busy      = (state_q != chte_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// zero counts as one bucket, counts above the table size saturate
	assign used_bc = (bc_q == '0) ? CFG_W'(1)
		: ((32'(bc_q) > NUM_BUCKETS) ? CFG_W'(NUM_BUCKETS) : bc_q);

	// one restoring step of key modulo bucket count
	assign trial = {rem_q, keysh_q[KEY_W-1]};
	assign rem_d = (trial >= {1'b0, div_q}) ? CFG_W'(trial - {1'b0, div_q}) : trial[CFG_W-1:0];

	assign scan_addr = base_q + ADDR_W'(slot_q);
	assign slot_last = (slot_q == SLOT_W'(CHAIN_DEPTH - 1));
	assign rd_entry  = chte_pkg::entry_t'(ram_rdata);
	assign match     = rd_entry.valid && (rd_entry.key == key_q);

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		fin_found  = 1'b0;
		fin_rd     = '0;
		fin_status = chte_pkg::STAT_DONE;
		unique case (state_q)
			chte_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == ADDR_W'(SLOTS - 1)) begin
					state_d = chte_pkg::S_IDLE;
				end
			end
			chte_pkg::S_IDLE: begin
				if (accept) begin
					if (chte_pkg::kind_t'(kind) == chte_pkg::KIND_RSVD) begin
						state_d = chte_pkg::S_FINISH;
					end else begin
						state_d = chte_pkg::S_DIV;
					end
				end
			end
			chte_pkg::S_DIV: begin
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					state_d = chte_pkg::S_BASE;
				end
			end
			chte_pkg::S_BASE: begin
				state_d = chte_pkg::S_READ;
			end
			chte_pkg::S_READ: begin
				ram_re  = 1'b1;
				state_d = chte_pkg::S_CHECK;
			end
			chte_pkg::S_CHECK: begin
				if (match || slot_last) begin
					state_d = chte_pkg::S_FINISH;
				end else begin
					state_d = chte_pkg::S_READ;
				end
			end
			chte_pkg::S_FINISH: begin
				state_d = chte_pkg::S_IDLE;
				unique case (kind_q)
					chte_pkg::KIND_SET: begin
						if (hit_q) begin
							fin_found  = 1'b1;
							fin_status = chte_pkg::STAT_PRESENT;
						end else if (free_q) begin
							ram_we          = 1'b1;
							ram_waddr       = free_addr_q;
							ram_wdata.valid = 1'b1;
							ram_wdata.key   = key_q;
							ram_wdata.value = value_q;
						end else begin
							fin_status = chte_pkg::STAT_FULL;
						end
					end
					chte_pkg::KIND_GET: begin
						if (hit_q) begin
							fin_found = 1'b1;
							fin_rd    = hit_value_q;
						end else begin
							fin_status = chte_pkg::STAT_MISS;
						end
					end
					chte_pkg::KIND_REMOVE: begin
						if (hit_q) begin
							fin_found = 1'b1;
							ram_we    = 1'b1;
							ram_waddr = hit_addr_q;
						end else begin
							fin_status = chte_pkg::STAT_MISS;
						end
					end
					chte_pkg::KIND_RSVD: begin
						fin_status = chte_pkg::STAT_DONE;
					end
				endcase
			end
			default: begin
				state_d = chte_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chte_pkg::S_CLEAR;
			clr_q   <= '0;
			bc_q    <= chte_pkg::BUCKET_COUNT_RESET;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			slot_q  <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == chte_pkg::S_FINISH);
			if (cfg_valid && cfg_ready) begin
				bc_q <= cfg_data;
			end
			if (state_q == chte_pkg::S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept) begin
				cnt_q  <= '0;
				slot_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			if (state_q == chte_pkg::S_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == chte_pkg::S_CHECK) begin
				if (match) begin
					hit_q <= 1'b1;
				end else if (!rd_entry.valid && !free_q) begin
					free_q <= 1'b1;
				end
				if (!slot_last) begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= chte_pkg::kind_t'(kind);
			key_q   <= key;
			keysh_q <= key;
			value_q <= value;
			div_q   <= used_bc;
			rem_q   <= '0;
		end
		if (state_q == chte_pkg::S_DIV) begin
			rem_q   <= rem_d;
			keysh_q <= {keysh_q[KEY_W-2:0], 1'b0};
		end
		if (state_q == chte_pkg::S_BASE) begin
			base_q <= ADDR_W'(rem_q) * ADDR_W'(CHAIN_DEPTH);
		end
		if (state_q == chte_pkg::S_CHECK) begin
			if (match) begin
				hit_addr_q  <= scan_addr;
				hit_value_q <= rd_entry.value;
			end else if (!rd_entry.valid && !free_q) begin
				free_addr_q <= scan_addr;
			end
		end
		if (state_q == chte_pkg::S_FINISH) begin
			found_q  <= fin_found;
			rd_q     <= fin_rd;
			status_q <= fin_status;
		end
	end

	chte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_chte_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_addr),
		.rdata (ram_rdata)
	);

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = rd_q;
	assign status     = status_q;

endmodule

>>> src/chte_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module chte_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/chte_checker.sv
// port-level checker for the chained hash table engine, bound to the top level
// depends on chte_pkg and chained_hash_table_engine_macros.svh
`include "chained_hash_table_engine_macros.svh"

module chte_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          found,
	input logic [chte_pkg::VALUE_W-1:0]  read_value,
	input logic [chte_pkg::STATUS_W-1:0] status
);

	`CHTE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "item accepted but block not busy")
	`CHTE_ASSERT_NEXT(a_single_done, clk, arst_n, done, !done, "result strobe held for two cycles")
	`CHTE_ASSERT_NOW(a_value_on_hit, clk, arst_n, done && (read_value != '0),
		found && (status == chte_pkg::STAT_DONE), "handle returned without a get hit")
	`CHTE_ASSERT_NOW(a_found_status, clk, arst_n, done && found,
		(status == chte_pkg::STAT_DONE) || (status == chte_pkg::STAT_PRESENT),
		"found item with a miss or full status")

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (.*);
